### rtl/core/lmtw_pkg.sv
// Shared constants and the result record of the two-wire LED driver controller.
package lmtw_pkg;

  // Buffer depth and waveform timing, in ticks.
  localparam logic [2:0] NUM_GRIDS      = 3'd6;
  localparam logic [2:0] HALF_BIT_TICKS = 3'd3;
  localparam logic [2:0] EDGE_TICKS     = 3'd2;

  // Command codes on the operation field.
  localparam logic [2:0] OP_IDLE    = 3'd0;
  localparam logic [2:0] OP_SET     = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_ALL_ON  = 3'd3;
  localparam logic [2:0] OP_ALL_OFF = 3'd4;
  localparam logic [2:0] OP_KEYS    = 3'd5;

  // Command bytes sent to the driver chip.
  localparam logic [7:0] CMD_MODE = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h88;
  localparam logic [7:0] CMD_KEYS = 8'h42;

  typedef struct packed {
    logic       clk_out;
    logic       dio_oe;
    logic       dio_out;
    logic       busy_res;
    logic [7:0] keys;
    logic       keys_valid;
    logic       ack_missing;
  } res_t;

endpackage

### rtl/core/led_matrix_two_wire_controller_top.sv
// Tick-level controller that drives the clock and data pins of a two-wire LED driver.
//
// Usage: every input transfer is one tick of the pin waveform and carries a command
// (operation, grid, segment) plus the sampled data pin level dio_in. Every input
// transfer yields exactly one result transfer with the pin levels for that tick,
// the busy flag, the key byte with its valid flag and the acknowledge status.
// Commands that arrive while a sequence runs are dropped; idle ticks hold the pins.
// Each result is registered. Throughput is one tick per cycle while in_stall is low,
// set by the single register stage that holds the controller state.
// A two-entry output buffer (result register plus skid register) decouples the
// channels: in_stall rises only when both entries are full, so one more tick is
// taken while a result waits on a stalled receiver.
// The brightness register is written through cfg_valid/cfg_ready/cfg_data and is
// read when the display control byte is loaded; cfg_ready is always high.
// Synchronous reset clears the segment buffer, sets brightness to 7, sets the pin state
// to clock low with the data pin driven low, and empties the output buffer.
module led_matrix_two_wire_controller_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] operation,
  input  logic [2:0] grid,
  input  logic [2:0] segment,
  input  logic       dio_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       clk_out,
  output logic       dio_oe,
  output logic       dio_out,
  output logic       busy_res,
  output logic [7:0] keys,
  output logic       keys_valid,
  output logic       ack_missing
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_S1   = 4'd1;
  localparam logic [3:0] PH_S2   = 4'd2;
  localparam logic [3:0] PH_WLO  = 4'd3;
  localparam logic [3:0] PH_WHI  = 4'd4;
  localparam logic [3:0] PH_ALO  = 4'd5;
  localparam logic [3:0] PH_AHI  = 4'd6;
  localparam logic [3:0] PH_KLO  = 4'd7;
  localparam logic [3:0] PH_KHI  = 4'd8;
  localparam logic [3:0] PH_P1   = 4'd9;
  localparam logic [3:0] PH_P2   = 4'd10;
  localparam logic [3:0] PH_P3   = 4'd11;

  localparam logic [1:0] TX_MODE = 2'd0;
  localparam logic [1:0] TX_DATA = 2'd1;
  localparam logic [1:0] TX_CTRL = 2'd2;
  localparam logic [1:0] TX_KEYS = 2'd3;

  // Pin level vector: clock in bit 2, output enable in bit 1, data in bit 0.
  localparam logic [2:0] PINS_RESET = 3'b010;

  logic [7:0] seg_buf [lmtw_pkg::NUM_GRIDS];
  logic [2:0] brightness;
  logic [3:0] step;
  logic [1:0] trans;
  logic [3:0] bit_cnt;
  logic [2:0] byte_cnt;
  logic [1:0] timer;
  logic [7:0] shift;
  logic [7:0] key_shift;
  logic [2:0] pins;
  logic       ack_fail;

  logic [3:0] step_next;
  logic [1:0] trans_next;
  logic [3:0] bit_cnt_next;
  logic [2:0] byte_cnt_next;
  logic [1:0] timer_next;
  logic [7:0] shift_next;
  logic [7:0] key_shift_next;
  logic [2:0] pins_next;
  logic       ack_fail_next;

  logic [3:0] ph;
  logic       start_disp;
  logic       start_keys;
  logic       busy_c;
  logic       valid_c;
  logic       accept;
  logic       take;
  lmtw_pkg::res_t res;
  lmtw_pkg::res_t out_data;
  lmtw_pkg::res_t skid_data;
  logic       skid_valid;

  function automatic logic [2:0] phase_len(input logic [3:0] p);
    case (p)
      PH_S1, PH_P1, PH_P2: phase_len = lmtw_pkg::EDGE_TICKS;
      PH_S2, PH_P3:        phase_len = 3'd1;
      default:             phase_len = lmtw_pkg::HALF_BIT_TICKS;
    endcase
  endfunction

  function automatic logic [2:0] phase_pins(input logic [3:0] p, input logic d,
                                            input logic [2:0] hold);
    case (p)
      PH_S1:          phase_pins = 3'b111;
      PH_S2:          phase_pins = 3'b110;
      PH_WLO:         phase_pins = {2'b01, d};
      PH_WHI:         phase_pins = {2'b11, d};
      PH_ALO, PH_KLO: phase_pins = 3'b000;
      PH_AHI, PH_KHI: phase_pins = 3'b100;
      PH_P1:          phase_pins = 3'b010;
      PH_P2:          phase_pins = 3'b110;
      PH_P3:          phase_pins = 3'b111;
      default:        phase_pins = hold;
    endcase
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;

  assign start_disp = (step == PH_IDLE) &&
    (((operation == lmtw_pkg::OP_SET || operation == lmtw_pkg::OP_CLEAR) &&
      grid < lmtw_pkg::NUM_GRIDS) ||
     operation == lmtw_pkg::OP_ALL_ON || operation == lmtw_pkg::OP_ALL_OFF);
  assign start_keys = (step == PH_IDLE) && (operation == lmtw_pkg::OP_KEYS);

  always_comb begin
    step_next      = step;
    trans_next     = trans;
    bit_cnt_next   = bit_cnt;
    byte_cnt_next  = byte_cnt;
    timer_next     = timer;
    shift_next     = shift;
    key_shift_next = key_shift;
    pins_next      = pins;
    ack_fail_next  = ack_fail;
    busy_c         = 1'b0;
    valid_c        = 1'b0;

    // A new command starts its sequence on the same tick.
    if (start_disp || start_keys) begin
      trans_next    = start_keys ? TX_KEYS : TX_MODE;
      shift_next    = start_keys ? lmtw_pkg::CMD_KEYS : lmtw_pkg::CMD_MODE;
      byte_cnt_next = 3'd0;
      bit_cnt_next  = 4'd0;
      timer_next    = 2'd0;
      step_next     = PH_S1;
    end

    ph = step_next;
    if (ph != PH_IDLE) begin
      busy_c    = 1'b1;
      pins_next = phase_pins(ph, shift_next[0], pins);
      if (({1'b0, timer_next} + 3'd1) >= phase_len(ph)) begin
        timer_next = 2'd0;
        case (ph)
          PH_S1: step_next = PH_S2;
          PH_S2: step_next = PH_WLO;
          PH_WLO: step_next = PH_WHI;
          PH_WHI: begin
            shift_next   = {1'b0, shift_next[7:1]};
            bit_cnt_next = bit_cnt_next + 4'd1;
            step_next    = (bit_cnt_next >= 4'd8) ? PH_ALO : PH_WLO;
          end
          PH_ALO: step_next = PH_AHI;
          PH_AHI: begin
            ack_fail_next = dio_in;
            if (trans_next == TX_KEYS) begin
              bit_cnt_next   = 4'd0;
              key_shift_next = 8'h00;
              step_next      = PH_KLO;
            end else if (trans_next == TX_DATA && byte_cnt_next < lmtw_pkg::NUM_GRIDS) begin
              shift_next    = seg_buf[byte_cnt_next];
              byte_cnt_next = byte_cnt_next + 3'd1;
              bit_cnt_next  = 4'd0;
              step_next     = PH_WLO;
            end else begin
              step_next = PH_P1;
            end
          end
          PH_KLO: begin
            key_shift_next = {dio_in, key_shift_next[7:1]};
            bit_cnt_next   = bit_cnt_next + 4'd1;
            step_next      = PH_KHI;
          end
          PH_KHI: step_next = (bit_cnt_next >= 4'd8) ? PH_P1 : PH_KLO;
          PH_P1: step_next = PH_P2;
          PH_P2: step_next = PH_P3;
          PH_P3: begin
            // The mode transaction chains into the data one, and that into control.
            if (trans_next == TX_MODE) begin
              trans_next    = TX_DATA;
              shift_next    = lmtw_pkg::CMD_ADDR;
              byte_cnt_next = 3'd0;
              bit_cnt_next  = 4'd0;
              step_next     = PH_S1;
            end else if (trans_next == TX_DATA) begin
              trans_next    = TX_CTRL;
              shift_next    = lmtw_pkg::CMD_CTRL | {5'd0, brightness};
              byte_cnt_next = 3'd0;
              bit_cnt_next  = 4'd0;
              step_next     = PH_S1;
            end else begin
              valid_c   = (trans_next == TX_KEYS);
              step_next = PH_IDLE;
            end
          end
          default: step_next = PH_IDLE;
        endcase
      end else begin
        timer_next = timer_next + 2'd1;
      end
    end

    res.clk_out     = pins_next[2];
    res.dio_oe      = pins_next[1];
    res.dio_out     = pins_next[0];
    res.busy_res    = busy_c;
    res.keys        = valid_c ? key_shift_next : 8'h00;
    res.keys_valid  = valid_c;
    res.ack_missing = ack_fail_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      brightness <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lmtw_pkg::NUM_GRIDS; i++) begin
        seg_buf[i] <= 8'h00;
      end
      step      <= PH_IDLE;
      trans     <= TX_MODE;
      bit_cnt   <= 4'd0;
      byte_cnt  <= 3'd0;
      timer     <= 2'd0;
      shift     <= 8'h00;
      key_shift <= 8'h00;
      pins      <= PINS_RESET;
      ack_fail  <= 1'b0;
    end else if (accept) begin
      if (start_disp) begin
        if (operation == lmtw_pkg::OP_SET || operation == lmtw_pkg::OP_CLEAR) begin
          seg_buf[grid][segment] <= (operation == lmtw_pkg::OP_SET);
        end else begin
          for (int i = 0; i < lmtw_pkg::NUM_GRIDS; i++) begin
            seg_buf[i] <= (operation == lmtw_pkg::OP_ALL_ON) ? 8'hFF : 8'h00;
          end
        end
      end
      step      <= step_next;
      trans     <= trans_next;
      bit_cnt   <= bit_cnt_next;
      byte_cnt  <= byte_cnt_next;
      timer     <= timer_next;
      shift     <= shift_next;
      key_shift <= key_shift_next;
      pins      <= pins_next;
      ack_fail  <= ack_fail_next;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || take) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign clk_out     = out_data.clk_out;
  assign dio_oe      = out_data.dio_oe;
  assign dio_out     = out_data.dio_out;
  assign busy_res    = out_data.busy_res;
  assign keys        = out_data.keys;
  assign keys_valid  = out_data.keys_valid;
  assign ack_missing = out_data.ack_missing;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the result register is empty");

  a_keys_in_sequence: assert property (@(posedge clk) disable iff (rst)
    (out_valid && keys_valid) |-> busy_res)
    else $error("key byte delivered outside a running sequence");

  a_keys_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !keys_valid) |-> (keys == 8'h00))
    else $error("key byte nonzero without keys_valid");

  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    (step == PH_IDLE) |-> (timer == 2'd0))
    else $error("phase timer running while no sequence is active");

endmodule

### test/tb_led_matrix_two_wire_controller_top.sv
// Testbench for the two-wire LED driver controller: directed table, random ticks, scoreboard.
`timescale 1ns / 100ps

module tb_led_matrix_two_wire_controller_top;

  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_PHASES      = 5;
  localparam int LONG_HOLD       = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_REPORTS     = 20;

  // Operation codes the block treats as idle ticks.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam lmtw_pkg::res_t RES_RESET = '{clk_out: 1'b0, dio_oe: 1'b1, dio_out: 1'b0,
                                           busy_res: 1'b0, keys: 8'h00, keys_valid: 1'b0,
                                           ack_missing: 1'b0};
  localparam lmtw_pkg::res_t RES_START = '{clk_out: 1'b1, dio_oe: 1'b1, dio_out: 1'b1,
                                           busy_res: 1'b1, keys: 8'h00, keys_valid: 1'b0,
                                           ack_missing: 1'b0};
  localparam lmtw_pkg::res_t RES_HELD_ACK = '{clk_out: 1'b1, dio_oe: 1'b1, dio_out: 1'b1,
                                              busy_res: 1'b0, keys: 8'h00, keys_valid: 1'b0,
                                              ack_missing: 1'b0};
  localparam lmtw_pkg::res_t RES_HELD_NACK = '{clk_out: 1'b1, dio_oe: 1'b1, dio_out: 1'b1,
                                               busy_res: 1'b0, keys: 8'h00, keys_valid: 1'b0,
                                               ack_missing: 1'b1};

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_HI, PH_START_LO, PH_BIT_LO, PH_BIT_HI, PH_ACK_LO, PH_ACK_HI,
    PH_KEY_LO, PH_KEY_HI, PH_STOP_LO, PH_STOP_RISE, PH_STOP_HI
  } phase_t;

  typedef enum logic [1:0] {TXN_MODE, TXN_DATA, TXN_CTRL, TXN_KEYS} txn_t;

  typedef struct {
    logic [2:0]     op;
    logic [2:0]     grid;
    logic [2:0]     seg;
    logic           din;
    bit             run_out;
    bit             typed;
    lmtw_pkg::res_t want;
  } row_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] operation;
  logic [2:0] grid;
  logic [2:0] segment;
  logic       dio_in;
  logic       out_valid;
  logic       out_stall;
  logic       clk_out;
  logic       dio_oe;
  logic       dio_out;
  logic       busy_res;
  logic [7:0] keys;
  logic       keys_valid;
  logic       ack_missing;

  // Controller mirror.
  logic [7:0] seg_buf [0:5];
  logic [2:0] bright;
  phase_t     phase;
  txn_t       txn;
  logic [3:0] bit_cnt;
  logic [2:0] byte_cnt;
  logic [1:0] ph_timer;
  logic [7:0] tx_byte;
  logic [7:0] key_byte;
  logic [2:0] pins;  // clock, output enable, data
  logic       ack_flag;

  lmtw_pkg::res_t tick_q [$];
  row_t dir_rows [$];
  int   err_count;
  int   res_count;
  int   idle_cycles;
  bit   long_hold_req;

  led_matrix_two_wire_controller_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .grid       (grid),
    .segment    (segment),
    .dio_in     (dio_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .clk_out    (clk_out),
    .dio_oe     (dio_oe),
    .dio_out    (dio_out),
    .busy_res   (busy_res),
    .keys       (keys),
    .keys_valid (keys_valid),
    .ack_missing(ack_missing)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int phase_len(phase_t p);
    case (p)
      PH_START_HI, PH_STOP_LO, PH_STOP_RISE: return int'(lmtw_pkg::EDGE_TICKS);
      PH_START_LO, PH_STOP_HI: return 1;
      default: return int'(lmtw_pkg::HALF_BIT_TICKS);
    endcase
  endfunction

  function automatic logic [2:0] phase_pins(phase_t p);
    case (p)
      PH_START_HI: return 3'b111;
      PH_START_LO: return 3'b110;
      PH_BIT_LO: return {2'b01, tx_byte[0]};
      PH_BIT_HI: return {2'b11, tx_byte[0]};
      PH_ACK_LO, PH_KEY_LO: return 3'b000;
      PH_ACK_HI, PH_KEY_HI: return 3'b100;
      PH_STOP_LO: return 3'b010;
      PH_STOP_RISE: return 3'b110;
      PH_STOP_HI: return 3'b111;
      default: return pins;
    endcase
  endfunction

  task automatic reset_mirror();
    for (int i = 0; i < 6; i++) seg_buf[i] = 8'h00;
    bright = 3'd7;
    phase = PH_IDLE;
    txn = TXN_MODE;
    bit_cnt = '0;
    byte_cnt = '0;
    ph_timer = '0;
    tx_byte = '0;
    key_byte = '0;
    pins = 3'b010;
    ack_flag = 1'b0;
  endtask

  task automatic start_txn(input txn_t t, input logic [7:0] b);
    txn = t;
    byte_cnt = '0;
    tx_byte = b;
    bit_cnt = '0;
    phase = PH_START_HI;
    ph_timer = '0;
  endtask

  task automatic finish_phase(input logic din, output logic keys_done);
    keys_done = 1'b0;
    case (phase)
      PH_START_HI: phase = PH_START_LO;
      PH_START_LO: phase = PH_BIT_LO;
      PH_BIT_LO: phase = PH_BIT_HI;
      PH_BIT_HI: begin
        tx_byte = tx_byte >> 1;
        bit_cnt = bit_cnt + 4'd1;
        phase = (bit_cnt >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
      end
      PH_ACK_LO: phase = PH_ACK_HI;
      PH_ACK_HI: begin
        ack_flag = din;
        if (txn == TXN_KEYS) begin
          bit_cnt = '0;
          key_byte = '0;
          phase = PH_KEY_LO;
        end else if (txn == TXN_DATA && byte_cnt < lmtw_pkg::NUM_GRIDS) begin
          // The address byte is followed by every buffer byte in order.
          tx_byte = seg_buf[byte_cnt];
          byte_cnt = byte_cnt + 3'd1;
          bit_cnt = '0;
          phase = PH_BIT_LO;
        end else begin
          phase = PH_STOP_LO;
        end
      end
      PH_KEY_LO: begin
        key_byte = {din, key_byte[7:1]};
        bit_cnt = bit_cnt + 4'd1;
        phase = PH_KEY_HI;
      end
      PH_KEY_HI: phase = (bit_cnt >= 4'd8) ? PH_STOP_LO : PH_KEY_LO;
      PH_STOP_LO: phase = PH_STOP_RISE;
      PH_STOP_RISE: phase = PH_STOP_HI;
      PH_STOP_HI: begin
        if (txn == TXN_MODE) begin
          start_txn(TXN_DATA, lmtw_pkg::CMD_ADDR);
        end else if (txn == TXN_DATA) begin
          start_txn(TXN_CTRL, lmtw_pkg::CMD_CTRL | {5'd0, bright});
        end else begin
          keys_done = (txn == TXN_KEYS);
          phase = PH_IDLE;
        end
      end
      default: phase = PH_IDLE;
    endcase
  endtask

  task automatic predict_tick(input logic [2:0] op, input logic [2:0] g, input logic [2:0] s,
                              input logic din, output lmtw_pkg::res_t r);
    logic keys_done;
    keys_done = 1'b0;
    r = '0;
    if (phase == PH_IDLE) begin
      if ((op == lmtw_pkg::OP_SET || op == lmtw_pkg::OP_CLEAR) && g < lmtw_pkg::NUM_GRIDS) begin
        seg_buf[g][s] = (op == lmtw_pkg::OP_SET);
        start_txn(TXN_MODE, lmtw_pkg::CMD_MODE);
      end else if (op == lmtw_pkg::OP_ALL_ON || op == lmtw_pkg::OP_ALL_OFF) begin
        for (int i = 0; i < 6; i++) seg_buf[i] = (op == lmtw_pkg::OP_ALL_ON) ? 8'hFF : 8'h00;
        start_txn(TXN_MODE, lmtw_pkg::CMD_MODE);
      end else if (op == lmtw_pkg::OP_KEYS) begin
        start_txn(TXN_KEYS, lmtw_pkg::CMD_KEYS);
      end
    end
    if (phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      pins = phase_pins(phase);
      if (int'(ph_timer) + 1 >= phase_len(phase)) begin
        ph_timer = '0;
        finish_phase(din, keys_done);
      end else begin
        ph_timer = ph_timer + 2'd1;
      end
    end
    r.clk_out = pins[2];
    r.dio_oe = pins[1];
    r.dio_out = pins[0];
    r.keys = keys_done ? key_byte : 8'h00;
    r.keys_valid = keys_done;
    r.ack_missing = ack_flag;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // One tick per transfer; the expected result is queued when the transfer is taken.
  task automatic send_tick(input logic [2:0] op, input logic [2:0] g, input logic [2:0] s,
                           input logic din, input bit typed, input lmtw_pkg::res_t want,
                           input bit no_gap);
    int             gap;
    lmtw_pkg::res_t pred;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    grid <= g;
    segment <= s;
    dio_in <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick(op, g, s, din, pred);
    tick_q.push_back(typed ? want : pred);
  endtask

  task automatic run_to_idle(input logic din, input bit random_din);
    while (phase != PH_IDLE)
      send_tick(lmtw_pkg::OP_IDLE, 3'd0, 3'd0, random_din ? 1'($urandom_range(0, 1)) : din,
                1'b0, '0, 1'b0);
  endtask

  task automatic write_brightness(input logic [2:0] v);
    in_valid <= 1'b0;
    while (tick_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bright = v;
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t result %0d: %s got %h expected %h", $time, res_count, field, got, want);
  endtask

  always @(posedge clk) begin
    lmtw_pkg::res_t got;
    lmtw_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{clk_out, dio_oe, dio_out, busy_res, keys, keys_valid, ack_missing};
      if (tick_q.size() == 0) begin
        report_mismatch("result with nothing expected", 8'(got), 8'h00);
      end else begin
        want = tick_q.pop_front();
        if (got.clk_out !== want.clk_out) report_mismatch("clk_out", got.clk_out, want.clk_out);
        if (got.dio_oe !== want.dio_oe) report_mismatch("dio_oe", got.dio_oe, want.dio_oe);
        if (got.dio_out !== want.dio_out) report_mismatch("dio_out", got.dio_out, want.dio_out);
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.keys !== want.keys) report_mismatch("keys", got.keys, want.keys);
        if (got.keys_valid !== want.keys_valid)
          report_mismatch("keys_valid", got.keys_valid, want.keys_valid);
        if (got.ack_missing !== want.ack_missing)
          report_mismatch("ack_missing", got.ack_missing, want.ack_missing);
      end
      res_count++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure: short stalls, calm stretches and one long hold-off on request.
  initial begin
    int r;
    out_stall <= 1'b0;
    wait (!rst);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 85) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(4, 30)) @(posedge clk);
        end else begin
          out_stall <= 1'b0;
          repeat ($urandom_range(60, 150)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int         r;
    logic [2:0] op;
    logic [2:0] g;
    logic [2:0] b;
    err_count = 0;
    res_count = 0;
    idle_cycles = 0;
    long_hold_req = 1'b0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    operation <= lmtw_pkg::OP_IDLE;
    grid <= '0;
    segment <= '0;
    dio_in <= 1'b0;
    reset_mirror();

    dir_rows.push_back('{lmtw_pkg::OP_IDLE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1, RES_RESET});
    dir_rows.push_back('{OP_SPARE_6, 3'd7, 3'd7, 1'b1, 1'b0, 1'b1, RES_RESET});
    dir_rows.push_back('{OP_SPARE_7, 3'd2, 3'd5, 1'b0, 1'b0, 1'b1, RES_RESET});
    dir_rows.push_back('{lmtw_pkg::OP_SET, 3'd6, 3'd0, 1'b0, 1'b0, 1'b1, RES_RESET});
    dir_rows.push_back('{lmtw_pkg::OP_CLEAR, 3'd7, 3'd7, 1'b1, 1'b0, 1'b1, RES_RESET});
    dir_rows.push_back('{lmtw_pkg::OP_KEYS, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1, RES_START});
    // Arrives while the key read runs, so it must be dropped.
    dir_rows.push_back('{lmtw_pkg::OP_ALL_ON, 3'd0, 3'd0, 1'b0, 1'b1, 1'b0, '0});
    dir_rows.push_back('{lmtw_pkg::OP_IDLE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1, RES_HELD_ACK});
    dir_rows.push_back('{lmtw_pkg::OP_KEYS, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, '0});
    // Display commands offered while the key read runs are all dropped.
    dir_rows.push_back('{lmtw_pkg::OP_SET, 3'd5, 3'd7, 1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{lmtw_pkg::OP_CLEAR, 3'd0, 3'd0, 1'b1, 1'b0, 1'b0, '0});
    dir_rows.push_back('{lmtw_pkg::OP_CLEAR, 3'd5, 3'd7, 1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{lmtw_pkg::OP_ALL_ON, 3'd1, 3'd2, 1'b0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{lmtw_pkg::OP_ALL_OFF, 3'd4, 3'd3, 1'b1, 1'b1, 1'b0, '0});
    dir_rows.push_back('{lmtw_pkg::OP_IDLE, 3'd0, 3'd0, 1'b1, 1'b0, 1'b1, RES_HELD_NACK});
    dir_rows.push_back('{lmtw_pkg::OP_KEYS, 3'd7, 3'd7, 1'b0, 1'b1, 1'b0, '0});
    dir_rows.push_back('{lmtw_pkg::OP_SET, 3'd3, 3'd4, 1'b0, 1'b0, 1'b0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      send_tick(dir_rows[k].op, dir_rows[k].grid, dir_rows[k].seg, dir_rows[k].din,
                dir_rows[k].typed, dir_rows[k].want, 1'b0);
      if (dir_rows[k].run_out) run_to_idle(dir_rows[k].din, 1'b0);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: b = 3'd0;
        1: b = 3'd7;
        2: b = 3'd3;
        3: b = 3'd5;
        default: b = 3'($urandom_range(0, 7));
      endcase
      write_brightness(b);
      if (ph == 1) long_hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        g = 3'($urandom_range(0, 7));
        if (phase == PH_IDLE) begin
          // Start real sequences most of the time; key reads are short, so favor them.
          r = $urandom_range(0, 99);
          if (r < 15) begin
            r = $urandom_range(0, 2);
            op = (r == 0) ? lmtw_pkg::OP_IDLE : ((r == 1) ? OP_SPARE_6 : OP_SPARE_7);
          end else if (r < 45) begin
            op = lmtw_pkg::OP_KEYS;
          end else if (r < 80) begin
            op = $urandom_range(0, 1) ? lmtw_pkg::OP_SET : lmtw_pkg::OP_CLEAR;
            if ($urandom_range(0, 3) != 0) g = 3'($urandom_range(0, 5));
          end else begin
            op = $urandom_range(0, 1) ? lmtw_pkg::OP_ALL_ON : lmtw_pkg::OP_ALL_OFF;
          end
        end else begin
          op = 3'($urandom_range(0, 7));
        end
        send_tick(op, g, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0, '0,
                  (i < 40));
      end
    end
    run_to_idle(1'b0, 1'b1);

    in_valid <= 1'b0;
    while (tick_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
